@@ design/fwba_pkg.sv @@
// Package for the FIFO weight budget admission unit.
// Shared types, constants, state and command/status structs; no dependencies.
package fwba_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QSUM_W      = QCNT_W + 1;
  localparam int DRAIN_LIMIT = 16;
  localparam int DRAIN_W     = $clog2(DRAIN_LIMIT + 1);

  localparam int ID_W     = 8;
  localparam int WEIGHT_W = 16;
  localparam int KIND_W   = 3;

  typedef enum logic [0:0] {
    CMD_ARRIVE = 1'b0,
    CMD_LEAVE  = 1'b1
  } adm_op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADMITTED  = 3'd0,
    KIND_QUEUED    = 3'd1,
    KIND_STOPPED   = 3'd2,
    KIND_RESTARTED = 3'd3,
    KIND_REJECTED  = 3'd4
  } adm_kind_t;

  typedef struct packed {
    logic                stopped;
    logic [WEIGHT_W-1:0] weight;
    logic [ID_W-1:0]     id;
  } adm_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_ARR_STOP,
    ST_LEAVE_SUB,
    ST_LEAVE_RD,
    ST_LEAVE_CHK,
    ST_FLUSH
  } adm_state_t;

  typedef struct packed {
    logic capture;
    logic sub_load;
    logic rd_head;
    logic arrive_do;
    logic arr_stop;
    logic drain_admit;
    logic head_stop;
    logic flush;
  } adm_cmd_t;

  typedef struct packed {
    logic cap_leave;
    logic q_empty;
    logic cap_fits;
    logic head_fits;
    logic head_stopped;
    logic drain_done;
    logic pend_valid;
    logic out_free;
  } adm_stat_t;

endpackage

@@ design/fwba_ctrl.sv @@
// Controller state machine for the admission unit.
// Depends on fwba_pkg; drives datapath commands from datapath status.
module fwba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  fwba_pkg::adm_stat_t stat,
  output fwba_pkg::adm_cmd_t  cmd
);
  import fwba_pkg::*;

  adm_state_t state_r, state_nxt;
  logic       push_ok;

  assign push_ok = !stat.pend_valid || stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LEAVE_SUB;
        end
      end
      ST_LEAVE_SUB: begin
        if (stat.cap_leave) begin
          cmd.sub_load = 1'b1;
          state_nxt    = ST_LEAVE_RD;
        end else begin
          state_nxt = ST_ARRIVE;
        end
      end
      ST_ARRIVE: begin
        if (push_ok) begin
          cmd.arrive_do = 1'b1;
          state_nxt = (stat.q_empty && !stat.cap_fits) ? ST_ARR_STOP : ST_FLUSH;
        end
      end
      ST_ARR_STOP: begin
        if (push_ok) begin
          cmd.arr_stop = 1'b1;
          state_nxt    = ST_FLUSH;
        end
      end
      ST_LEAVE_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = ST_LEAVE_CHK;
      end
      ST_LEAVE_CHK: begin
        if (stat.q_empty) begin
          state_nxt = ST_FLUSH;
        end else if (!stat.drain_done && stat.head_fits) begin
          if (push_ok) begin
            cmd.drain_admit = 1'b1;
            state_nxt       = ST_LEAVE_RD;
          end
        end else if (!stat.head_stopped && !stat.head_fits) begin
          if (push_ok) begin
            cmd.head_stop = 1'b1;
            state_nxt     = ST_FLUSH;
          end
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/fwba_dp.sv @@
// Datapath of the admission unit: load, budget, wait queue memory, event staging.
// Depends on fwba_pkg; driven by fwba_ctrl commands.
module fwba_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [fwba_pkg::WEIGHT_W-1:0]  cfg_wr_data,
  input  logic [23:0]                    in_tdata,
  input  logic                           in_tuser,
  input  fwba_pkg::adm_cmd_t             cmd,
  output fwba_pkg::adm_stat_t            stat,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,
  output logic [2:0]                     out_tuser,
  output logic                           out_tlast
);
  import fwba_pkg::*;

  logic [WEIGHT_W-1:0] budget_r;
  logic [WEIGHT_W-1:0] load_r, load_nxt;
  logic [QADDR_W-1:0]  head_r, head_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic [DRAIN_W-1:0]  drain_r;

  adm_op_t             cap_op_r;
  logic [ID_W-1:0]     cap_id_r;
  logic [WEIGHT_W-1:0] cap_w_r;

  adm_entry_t          mem [QUEUE_DEPTH];
  adm_entry_t          rd_entry_r;
  logic                wr_en;
  logic [QADDR_W-1:0]  wr_addr;
  adm_entry_t          wr_data;
  logic [QSUM_W-1:0]   tail_sum;
  logic [QADDR_W-1:0]  tail;

  logic                pend_valid_r;
  logic [ID_W-1:0]     pend_id_r;
  adm_kind_t           pend_kind_r;
  logic                out_valid_r;
  logic [ID_W-1:0]     out_id_r;
  adm_kind_t           out_kind_r;
  logic                out_last_r;

  logic                q_empty, q_full, cap_fits, head_fits, out_free;
  logic                arr_admit, arr_enq, push;
  logic [ID_W-1:0]     new_id;
  adm_kind_t           new_kind;

  assign q_empty   = (count_r == '0);
  assign q_full    = (count_r >= QCNT_W'(QUEUE_DEPTH));
  assign cap_fits  = ({1'b0, load_r} + {1'b0, cap_w_r}) <= {1'b0, budget_r};
  assign head_fits = ({1'b0, load_r} + {1'b0, rd_entry_r.weight}) <= {1'b0, budget_r};
  assign out_free  = !out_valid_r || out_tready;
  assign arr_admit = q_empty && cap_fits;
  assign arr_enq   = !arr_admit && !q_full;

  assign stat.cap_leave    = (cap_op_r == CMD_LEAVE);
  assign stat.q_empty      = q_empty;
  assign stat.cap_fits     = cap_fits;
  assign stat.head_fits    = head_fits;
  assign stat.head_stopped = rd_entry_r.stopped;
  assign stat.drain_done   = (drain_r == DRAIN_W'(DRAIN_LIMIT));
  assign stat.pend_valid   = pend_valid_r;
  assign stat.out_free     = out_free;

  // tail slot = (head + count) mod depth, sum stays below twice the depth
  assign tail_sum = QSUM_W'(head_r) + QSUM_W'(count_r);
  assign tail = (tail_sum >= QSUM_W'(QUEUE_DEPTH)) ?
                QADDR_W'(tail_sum - QSUM_W'(QUEUE_DEPTH)) : QADDR_W'(tail_sum);

  always_comb begin
    load_nxt = load_r;
    if (cmd.sub_load) begin
      load_nxt = (cap_w_r >= load_r) ? '0 : load_r - cap_w_r;
    end else if (cmd.arrive_do && arr_admit) begin
      load_nxt = load_r + cap_w_r;
    end else if (cmd.drain_admit) begin
      load_nxt = load_r + rd_entry_r.weight;
    end
  end

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    if (cmd.arrive_do && arr_enq) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (cmd.drain_admit) begin
      count_nxt = count_r - QCNT_W'(1);
      head_nxt  = (head_r == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + QADDR_W'(1);
    end
  end

  always_comb begin
    wr_en           = (cmd.arrive_do && arr_enq) || cmd.head_stop;
    wr_addr         = cmd.head_stop ? head_r : tail;
    wr_data.stopped = cmd.head_stop ? 1'b1 : q_empty;
    wr_data.weight  = cmd.head_stop ? rd_entry_r.weight : cap_w_r;
    wr_data.id      = cmd.head_stop ? rd_entry_r.id : cap_id_r;
  end

  always_comb begin
    push     = cmd.arrive_do || cmd.arr_stop || cmd.drain_admit || cmd.head_stop;
    new_id   = cap_id_r;
    new_kind = KIND_STOPPED;
    if (cmd.arrive_do) begin
      new_kind = arr_admit ? KIND_ADMITTED : (q_full ? KIND_REJECTED : KIND_QUEUED);
    end else if (cmd.drain_admit) begin
      new_id   = rd_entry_r.id;
      new_kind = rd_entry_r.stopped ? KIND_RESTARTED : KIND_ADMITTED;
    end else if (cmd.head_stop) begin
      new_id = rd_entry_r.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '1;
      load_r   <= '0;
      head_r   <= '0;
      count_r  <= '0;
      drain_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
      load_r  <= load_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cmd.sub_load) begin
        drain_r <= '0;
      end else if (cmd.drain_admit) begin
        drain_r <= drain_r + DRAIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_op_r <= adm_op_t'(in_tuser);
      cap_id_r <= in_tdata[ID_W-1:0];
      cap_w_r  <= in_tdata[ID_W+WEIGHT_W-1:ID_W];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_head) begin
      rd_entry_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (push) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if ((push && pend_valid_r) || cmd.flush) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pend_id_r   <= new_id;
      pend_kind_r <= new_kind;
    end
    if ((push && pend_valid_r) || cmd.flush) begin
      out_id_r   <= pend_id_r;
      out_kind_r <= pend_kind_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= QADDR_W'(QUEUE_DEPTH - 1))
    else $error("queue head beyond depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ((push && pend_valid_r) || cmd.flush) |-> out_free)
    else $error("output register overwritten while stalled");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.flush && !push) |=> !pend_valid_r)
    else $error("staged event kept after flush");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_admit |-> !q_empty)
    else $error("admit from empty queue");

endmodule

@@ design/fifo_weight_budget_admission_unit.sv @@
// Strict-FIFO admission against a shared 16-bit load budget. An arrive request
// (in_tuser 0) is admitted at once when nobody waits and load + weight fits the
// budget, otherwise it joins a 16-entry wait queue or is rejected when full; a
// leave (in_tuser 1) lowers the load, saturating at zero, then admits waiting
// heads in order while they fit, at most sixteen per leave. Each input takes one
// item and produces zero or more events, the last one flagged by out_tlast.
// A leave reads each waiting head through the queue memory's single registered
// read port, then checks it. A new item is taken only back in idle, and output
// back-pressure can stall the unit. The budget must be written via cfg_wr_en only
// while idle; the block itself does not enforce this.
// Depends on fwba_pkg, fwba_ctrl and fwba_dp.
module fifo_weight_budget_admission_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // load_budget
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // requester_id[7:0], weight[23:8]
  input  logic        in_tuser,      // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // event_id[7:0]
  output logic [2:0]  out_tuser,     // event_kind[2:0]
  output logic        out_tlast      // last_event
);
  import fwba_pkg::*;

  adm_cmd_t  cmd;
  adm_stat_t stat;

  fwba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fwba_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for fifo_weight_budget_admission_unit: a directed table,
// then randomized arrive/leave traffic in phases with different load budgets.
// Depends on fwba_pkg and the unit's RTL; expected events come from the table or a predictor.
module tb;
  import fwba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIMIT     = 200000;
  localparam int          IDLE_PCT  = 14;
  localparam int          SETTLE    = 30;
  localparam int          HOLD_CYC  = 300;
  localparam int          N_PHASES  = 7;
  localparam int          PHASE_LEN = 36;

  typedef enum logic { ROW_ITEM, ROW_BUDGET } row_act_t;

  typedef struct packed {
    row_act_t            act;
    adm_op_t             op;
    logic [ID_W-1:0]     id;
    logic [WEIGHT_W-1:0] weight;
    logic [4:0]          reps;
    logic [1:0]          n_typed;  // 0: take events from the predictor
    adm_kind_t           k0;
    adm_kind_t           k1;
  } dir_row_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    adm_kind_t       kind;
    logic            last;
  } adm_event_t;

  localparam dir_row_t SCRIPT [13] = '{
    '{ROW_ITEM,   CMD_ARRIVE, 8'h00, 16'hFFFF, 5'd1,  2'd1, KIND_ADMITTED, KIND_ADMITTED},
    '{ROW_ITEM,   CMD_ARRIVE, 8'hFF, 16'h0000, 5'd1,  2'd1, KIND_ADMITTED, KIND_ADMITTED},
    '{ROW_ITEM,   CMD_ARRIVE, 8'h11, 16'h0001, 5'd1,  2'd2, KIND_QUEUED,   KIND_STOPPED},
    '{ROW_ITEM,   CMD_ARRIVE, 8'h12, 16'h0005, 5'd1,  2'd1, KIND_QUEUED,   KIND_QUEUED},
    '{ROW_ITEM,   CMD_LEAVE,  8'hA5, 16'hFFFF, 5'd1,  2'd0, KIND_ADMITTED, KIND_ADMITTED},
    '{ROW_BUDGET, CMD_ARRIVE, 8'h00, 16'h0000, 5'd1,  2'd0, KIND_ADMITTED, KIND_ADMITTED},
    '{ROW_ITEM,   CMD_LEAVE,  8'h5A, 16'hFFFF, 5'd1,  2'd0, KIND_ADMITTED, KIND_ADMITTED},
    '{ROW_ITEM,   CMD_ARRIVE, 8'h21, 16'h0001, 5'd1,  2'd2, KIND_QUEUED,   KIND_STOPPED},
    '{ROW_ITEM,   CMD_ARRIVE, 8'h30, 16'h0000, 5'd15, 2'd1, KIND_QUEUED,   KIND_QUEUED},
    '{ROW_ITEM,   CMD_ARRIVE, 8'h55, 16'h0000, 5'd1,  2'd1, KIND_REJECTED, KIND_REJECTED},
    '{ROW_ITEM,   CMD_LEAVE,  8'h00, 16'h0000, 5'd1,  2'd0, KIND_ADMITTED, KIND_ADMITTED},
    '{ROW_BUDGET, CMD_ARRIVE, 8'h00, 16'hFFFF, 5'd1,  2'd0, KIND_ADMITTED, KIND_ADMITTED},
    '{ROW_ITEM,   CMD_LEAVE,  8'hFF, 16'h0000, 5'd1,  2'd0, KIND_ADMITTED, KIND_ADMITTED}
  };

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;   // requester_id[7:0], weight[23:8]
  logic        in_tuser    = 1'b0; // command
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;          // event_id[7:0]
  logic [2:0]  out_tuser;          // event_kind[2:0]
  logic        out_tlast;

  fifo_weight_budget_admission_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int unsigned cycle_cnt = 0;
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // predictor state
  logic [WEIGHT_W-1:0] budget = 16'hFFFF;
  logic [WEIGHT_W-1:0] load   = '0;
  adm_entry_t          waitq [QUEUE_DEPTH];
  int                  wait_head = 0;
  int                  wait_cnt  = 0;
  adm_event_t          ev_buf [DRAIN_LIMIT+1];
  int                  ev_n;

  adm_event_t          due_events [$];
  logic [WEIGHT_W-1:0] live_w [$];     // weights admitted and not yet sent as leaves
  int                  errors = 0;
  bit                  calm    = 1'b0;
  bit                  hold_go = 1'b0;

  function automatic bit fits(input logic [WEIGHT_W-1:0] w);
    return ({1'b0, load} + {1'b0, w}) <= {1'b0, budget};
  endfunction

  task automatic log_event(input logic [ID_W-1:0] id, input adm_kind_t kind);
    ev_buf[ev_n] = '{id, kind, 1'b0};
    ev_n++;
  endtask

  task automatic apply_request(input adm_op_t op, input logic [ID_W-1:0] id,
                               input logic [WEIGHT_W-1:0] w);
    int slot;
    ev_n = 0;
    if (op == CMD_ARRIVE) begin
      if (wait_cnt == 0 && fits(w)) begin
        load = load + w;
        live_w.push_back(w);
        log_event(id, KIND_ADMITTED);
      end else if (wait_cnt >= QUEUE_DEPTH) begin
        log_event(id, KIND_REJECTED);
      end else begin
        slot = (wait_head + wait_cnt) % QUEUE_DEPTH;
        waitq[slot] = '{stopped: (wait_cnt == 0), weight: w, id: id};
        wait_cnt++;
        log_event(id, KIND_QUEUED);
        if (waitq[slot].stopped) log_event(id, KIND_STOPPED);
      end
    end else begin
      load = (w >= load) ? '0 : load - w;
      while (wait_cnt > 0 && ev_n < DRAIN_LIMIT && fits(waitq[wait_head].weight)) begin
        load = load + waitq[wait_head].weight;
        live_w.push_back(waitq[wait_head].weight);
        log_event(waitq[wait_head].id,
                  waitq[wait_head].stopped ? KIND_RESTARTED : KIND_ADMITTED);
        wait_head = (wait_head + 1) % QUEUE_DEPTH;
        wait_cnt--;
      end
      if (wait_cnt > 0 && !waitq[wait_head].stopped && !fits(waitq[wait_head].weight)) begin
        waitq[wait_head].stopped = 1'b1;
        log_event(waitq[wait_head].id, KIND_STOPPED);
      end
    end
  endtask

  task automatic send_item(input adm_op_t op, input logic [ID_W-1:0] id,
                           input logic [WEIGHT_W-1:0] w, input int n_typed,
                           input adm_kind_t k0, input adm_kind_t k1);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {w, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_request(op, id, w);
    if (n_typed == 0) begin
      for (int i = 0; i < ev_n; i++)
        due_events.push_back('{ev_buf[i].id, ev_buf[i].kind, i == ev_n - 1});
    end else begin
      due_events.push_back('{id, k0, n_typed == 1});
      if (n_typed == 2) due_events.push_back('{id, k1, 1'b1});
    end
  endtask

  // drop valid, wait for every expected event, then let a silent item finish
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_budget(input logic [WEIGHT_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    budget = v;
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return WEIGHT_W'($urandom_range(budget / 3));
    if (r < 85) return WEIGHT_W'($urandom_range(budget));
    if (r < 95) return WEIGHT_W'($urandom_range(16'hFFFF));
    return r[0] ? 16'hFFFF : 16'h0000;
  endfunction

  // receiver: random stalls, one long hold-off, a calm stretch
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        hold_left = HOLD_CYC;
        hold_done = 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    adm_event_t exp_ev;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_events.size() == 0) begin
        if (errors < 10)
          $display("unexpected event: id %02h kind %0d last %b", out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        exp_ev = due_events.pop_front();
        if (out_tdata !== exp_ev.id || out_tuser !== exp_ev.kind || out_tlast !== exp_ev.last) begin
          if (errors < 10)
            $display("mismatch: expected id %02h kind %0d last %b, got id %02h kind %0d last %b",
                     exp_ev.id, exp_ev.kind, exp_ev.last, out_tdata, out_tuser, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    dir_row_t            row;
    logic [WEIGHT_W-1:0] w;
    int unsigned         r;
    int                  k;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[i]) begin
      row = SCRIPT[i];
      if (row.act == ROW_BUDGET) begin
        write_budget(row.weight);
      end else begin
        for (int rep = 0; rep < row.reps; rep++)
          send_item(row.op, ID_W'(row.id + rep), row.weight, int'(row.n_typed),
                    row.k0, row.k1);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: write_budget(16'd2000);
        1: write_budget(16'hFFFF);
        2: write_budget(16'd0);
        3: write_budget(16'd500);
        5: write_budget(16'd40);
        default: write_budget(WEIGHT_W'($urandom_range(16'hFFFF)));
      endcase
      calm = (ph == 1);
      if (ph == 3) hold_go = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(99);
        if (live_w.size() > 0 && r < 40) begin
          k = $urandom_range(live_w.size() - 1);
          w = live_w[k];
          live_w.delete(k);
          send_item(CMD_LEAVE, ID_W'($urandom_range(255)), w, 0,
                    KIND_ADMITTED, KIND_ADMITTED);
        end else if (r < 46) begin
          w = r[0] ? WEIGHT_W'($urandom_range(16'hFFFF)) : WEIGHT_W'($urandom_range(budget));
          send_item(CMD_LEAVE, ID_W'($urandom_range(255)), w, 0,
                    KIND_ADMITTED, KIND_ADMITTED);
        end else begin
          send_item(CMD_ARRIVE, ID_W'($urandom_range(255)), pick_weight(), 0,
                    KIND_ADMITTED, KIND_ADMITTED);
        end
      end
    end
    calm = 1'b0;

    settle();
    if (errors == 0 && due_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fwba_pkg.sv
design/fwba_ctrl.sv
design/fwba_dp.sv
design/fifo_weight_budget_admission_unit.sv
tb/sv/tb.sv
